// ----- hdl/fir_filter_full_convolution_assert.svh -----
// Assertion macros used by the FIR filter top level.
`ifndef FIR_FILTER_FULL_CONVOLUTION_ASSERT_SVH
`define FIR_FILTER_FULL_CONVOLUTION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("FIR filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("FIR filter assertion failed");

`endif

// ----- hdl/ffc_pkg.sv -----
// Package with the shared types and constants of the FIR filter.
`timescale 1ns / 1ps
`default_nettype none
package ffc_pkg;

  localparam int DATA_W     = 16;
  localparam int IDX_W      = 4;
  localparam int TAP_W      = 5;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_W     = 15;
  localparam int ROUND_HALF = 16384;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int IN_TDATA_W = 24;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MAC   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic coef_wr;
    logic smp_wr;
    logic smp_zero;
    logic acc_clr;
    logic issue;
    logic out_load;
    logic out_last;
    logic dl_clr;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/fir_filter_full_convolution.sv -----
// Top level of the streaming FIR filter with full convolution tail.
//
//   Channel   Direction  Contents
//   s_axis    in         coefficient load or sample word, end-of-signal mark
//   m_axis    out        rounded, saturated output sample and clip flag
//   cfg       in         tap count register write
//
// A coefficient word is written when it is taken. A sample word runs its T active taps
// through one shared multiply-accumulate unit, and the input is freed once its output
// is loaded; a sample with the end mark gives T outputs, the later ones from zero
// samples fed into the delay line, and frees the input after the last of them.
// After reset the coefficients and the delay line read as zero (valid bits, no
// clearing pass) and the tap count is one. A waiting output word stalls only the
// next output; a new input word is taken once the current one is finished.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_filter_full_convolution_assert.svh"
module fir_filter_full_convolution #(
  parameter int MAX_TAPS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_wr_en,
  input  wire [ffc_pkg::TAP_W-1:0]             cfg_wr_data,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] coef_index, [19:4] value, [23:20] zero
  input  wire [ffc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  // [0] opcode
  input  wire                                  s_axis_tuser,
  input  wire                                  s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [15:0] filtered_sample
  output logic [ffc_pkg::DATA_W-1:0]           m_axis_tdata,
  // [0] saturated
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  ffc_pkg::cmd_t cmd;
  ffc_pkg::sts_t sts;
  logic [AW-1:0] coef_rd_addr;
  logic [ffc_pkg::IDX_W-1:0] in_coef_index;
  logic signed [ffc_pkg::DATA_W-1:0] in_value;

  assign in_coef_index = s_axis_tdata[ffc_pkg::IDX_W-1:0];
  assign in_value      = s_axis_tdata[ffc_pkg::IDX_W +: ffc_pkg::DATA_W];

  ffc_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_opcode   (s_axis_tuser),
    .in_eos      (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .sts         (sts),
    .cmd         (cmd),
    .coef_rd_addr(coef_rd_addr)
  );

  ffc_datapath #(
    .MAX_TAPS(MAX_TAPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .coef_rd_addr (coef_rd_addr),
    .in_coef_index(in_coef_index),
    .in_value     (in_value),
    .sts          (sts),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  `FFC_ASSERT_SAME(a_idle_pipe_empty, clk, rst, s_axis_tready, !sts.pipe_busy)
  `FFC_ASSERT_NEXT(a_last_returns_idle, clk, rst, cmd.out_load && cmd.out_last, s_axis_tready)
  `FFC_ASSERT_SAME(a_valid_from_load, clk, rst, $rose(m_axis_tvalid), $past(cmd.out_load))
  `FFC_ASSERT_SAME(a_no_load_when_busy, clk, rst, cmd.out_load, !sts.pipe_busy && sts.out_free)

endmodule
`default_nettype wire

// ----- hdl/ffc_datapath.sv -----
// Datapath: coefficient and sample memories, multiply-accumulate pipe, rounding, output.
`timescale 1ns / 1ps
`default_nettype none
module ffc_datapath #(
  parameter int MAX_TAPS = 16
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire ffc_pkg::cmd_t                       cmd,
  input  wire [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_rd_addr,
  input  wire [ffc_pkg::IDX_W-1:0]                 in_coef_index,
  input  wire signed [ffc_pkg::DATA_W-1:0]         in_value,
  output ffc_pkg::sts_t                            sts,
  output logic                                     m_axis_tvalid,
  input  wire                                      m_axis_tready,
  output logic [ffc_pkg::DATA_W-1:0]               m_axis_tdata,
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tlast
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACC_W = ffc_pkg::PROD_W + 1 + $clog2(MAX_TAPS);
  localparam int DW    = ffc_pkg::DATA_W;

  logic signed [DW-1:0] coef_mem [MAX_TAPS];
  logic signed [DW-1:0] dl_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]  coef_vld;
  logic [MAX_TAPS-1:0]  dl_vld;
  logic [AW-1:0]        wp;
  logic [AW-1:0]        rdp;
  logic signed [DW-1:0] coef_q;
  logic signed [DW-1:0] dl_q;
  logic                 coef_ok;
  logic                 dl_ok;
  logic                 v1;
  logic                 v2;
  logic signed [ffc_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] quo;
  logic signed [DW-1:0]    res;
  logic                    res_sat;
  logic signed [DW-1:0]    mul_a;
  logic signed [DW-1:0]    mul_b;
  logic                    coef_wr_ok;
  logic signed [DW-1:0]    smp_data;

  assign coef_wr_ok = cmd.coef_wr && (32'(in_coef_index) < 32'(MAX_TAPS));
  assign smp_data   = cmd.smp_zero ? '0 : in_value;

  always_ff @(posedge clk) begin
    if (coef_wr_ok) begin
      coef_mem[AW'(in_coef_index)] <= in_value;
    end
    if (cmd.smp_wr) begin
      dl_mem[wp] <= smp_data;
    end
    if (cmd.issue) begin
      coef_q <= coef_mem[coef_rd_addr];
      dl_q   <= dl_mem[rdp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      dl_vld   <= '0;
      wp       <= '0;
      rdp      <= '0;
      coef_ok  <= 1'b0;
      dl_ok    <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (coef_wr_ok) begin
        coef_vld[AW'(in_coef_index)] <= 1'b1;
      end
      if (cmd.dl_clr) begin
        dl_vld <= '0;
      end else if (cmd.smp_wr) begin
        dl_vld[wp] <= 1'b1;
      end
      if (cmd.smp_wr) begin
        rdp <= wp;
        wp  <= (wp == AW'(MAX_TAPS - 1)) ? '0 : wp + AW'(1);
      end else if (cmd.issue) begin
        rdp <= (rdp == '0) ? AW'(MAX_TAPS - 1) : rdp - AW'(1);
      end
      if (cmd.issue) begin
        coef_ok <= coef_vld[coef_rd_addr];
        dl_ok   <= dl_vld[rdp];
      end
    end
  end

  assign mul_a = coef_ok ? coef_q : '0;
  assign mul_b = dl_ok ? dl_q : '0;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round to nearest with ties upward, then clip to the sample range.
  always_comb begin
    rnd     = acc + $signed(ACC_W'(ffc_pkg::ROUND_HALF));
    quo     = rnd >>> ffc_pkg::FRAC_W;
    res_sat = 1'b0;
    res     = quo[DW-1:0];
    if (quo > $signed(ACC_W'(ffc_pkg::SAMPLE_MAX))) begin
      res     = DW'(ffc_pkg::SAMPLE_MAX);
      res_sat = 1'b1;
    end else if (quo < $signed(ACC_W'(ffc_pkg::SAMPLE_MIN))) begin
      res     = DW'(ffc_pkg::SAMPLE_MIN);
      res_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= res;
      m_axis_tuser <= res_sat;
      m_axis_tlast <= cmd.out_last;
    end
  end

  assign sts.pipe_busy = v1 | v2;
  assign sts.out_free  = !m_axis_tvalid || m_axis_tready;

endmodule
`default_nettype wire

// ----- hdl/ffc_ctrl.sv -----
// Controller: tap count register, sequencing of taps, outputs and tail outputs.
`timescale 1ns / 1ps
`default_nettype none
module ffc_ctrl #(
  parameter int MAX_TAPS = 16
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      cfg_wr_en,
  input  wire [ffc_pkg::TAP_W-1:0]                 cfg_wr_data,
  input  wire                                      in_valid,
  input  wire                                      in_opcode,
  input  wire                                      in_eos,
  output logic                                     in_ready,
  input  wire ffc_pkg::sts_t                       sts,
  output ffc_pkg::cmd_t                            cmd,
  output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_rd_addr
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int CW = (TW > ffc_pkg::TAP_W) ? TW : ffc_pkg::TAP_W;

  ffc_pkg::state_t state;
  ffc_pkg::state_t state_next;
  logic [ffc_pkg::TAP_W-1:0] tap_count;
  logic [AW-1:0] k;
  logic [AW-1:0] k_next;
  logic [AW-1:0] tc;
  logic [AW-1:0] tc_next;
  logic          eos_q;
  logic          eos_q_next;
  logic [CW-1:0] tap_ext;
  logic [TW-1:0] taps;
  logic [TW-1:0] taps_m1;

  assign tap_ext = CW'(tap_count);

  always_comb begin
    if (tap_ext == '0) begin
      taps = TW'(1);
    end else if (tap_ext > CW'(MAX_TAPS)) begin
      taps = TW'(MAX_TAPS);
    end else begin
      taps = TW'(tap_ext);
    end
    taps_m1 = taps - TW'(1);
  end

  assign in_ready     = (state == ffc_pkg::ST_IDLE);
  assign coef_rd_addr = k;

  always_comb begin
    state_next = state;
    k_next     = k;
    tc_next    = tc;
    eos_q_next = eos_q;
    cmd        = '0;
    case (state)
      ffc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == ffc_pkg::OP_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.smp_wr  = 1'b1;
            cmd.acc_clr = 1'b1;
            k_next      = '0;
            eos_q_next  = in_eos;
            tc_next     = in_eos ? AW'(taps_m1) : '0;
            state_next  = ffc_pkg::ST_MAC;
          end
        end
      end
      ffc_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
        k_next    = k + AW'(1);
        if (TW'(k) == taps_m1) begin
          state_next = ffc_pkg::ST_DRAIN;
        end
      end
      ffc_pkg::ST_DRAIN: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = eos_q && (tc == '0);
          if (tc != '0) begin
            // Tail output: feed a zero sample and run the taps again.
            tc_next      = tc - AW'(1);
            cmd.smp_wr   = 1'b1;
            cmd.smp_zero = 1'b1;
            cmd.acc_clr  = 1'b1;
            k_next       = '0;
            state_next   = ffc_pkg::ST_MAC;
          end else begin
            cmd.dl_clr = eos_q;
            eos_q_next = 1'b0;
            state_next = ffc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ffc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffc_pkg::ST_IDLE;
      tap_count <= ffc_pkg::TAP_W'(1);
      k         <= '0;
      tc        <= '0;
      eos_q     <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      tc    <= tc_next;
      eos_q <= eos_q_next;
      if (cfg_wr_en) begin
        tap_count <= cfg_wr_data;
      end
    end
  end

endmodule
`default_nettype wire
